[sv/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset as the disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression that must never be true at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

[sv/pqd_pkg.sv]
// Package for the packed quaternion decoder: widths, fixed-point constants,
// slot placement codes and the structs carried along the pipeline. No dependencies.
`timescale 1ns / 1ps

package pqd_pkg;

	localparam int WORD_W     = 16;
	localparam int MAG_W      = 17;             // |v| reaches 32768
	localparam int SCALE_W    = 17;
	localparam int M_W        = 32;             // stored magnitude, 32 fraction bits
	localparam int SQ_W       = 60;             // (m*m) >> 4
	localparam int SUM_W      = 61;
	localparam int RAD_W      = 62;             // radicand padded to whole bit pairs
	localparam int ROOT_W     = 31;
	localparam int REM_W      = 33;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int PQD_LATENCY = SQRT_STEPS + 5;

	// round(0.70710678118 * 2^32 / 32767)
	localparam logic [SCALE_W-1:0] SCALE_Q32 = 17'd92685;
	localparam logic [WORD_W-1:0]  WORD_MASK = 16'hFFFE;
	localparam logic [14:0]        Q15_MAX   = 15'h7FFF;

	// {word_b[0], word_a[0]} picks where the rebuilt component lands
	typedef enum logic [1:0] {
		SLOT_ABCD = 2'b00,
		SLOT_BCDA = 2'b01,
		SLOT_CDAB = 2'b10,
		SLOT_DABC = 2'b11
	} slot_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] comp_a;
		logic signed [WORD_W-1:0] comp_b;
		logic signed [WORD_W-1:0] comp_c;
		slot_t                    slot;
		logic                     neg_d;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sqrt_t;

endpackage

[sv/pqd_front.sv]
// Front end: unpack words, scale, square, sum and form the radicand (four stages).
// Depends on pqd_pkg.
`timescale 1ns / 1ps

module pqd_front import pqd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [WORD_W-1:0] word_a,
	input  logic [WORD_W-1:0] word_b,
	input  logic [WORD_W-1:0] word_c,
	output logic              vld_s4,
	output side_t             side_s4,
	output logic [RAD_W-1:0]  rad_s4
);

	localparam logic [SUM_W-1:0] ONE_Q60 = SUM_W'(1) << SQ_W;

	logic [WORD_W-1:0]          words [3];
	logic [WORD_W-1:0]          raw   [3];
	logic [MAG_W-1:0]           mag   [3];
	logic [MAG_W+SCALE_W-1:0]   mprod [3];
	logic [2*M_W-1:0]           sq_full [3];
	logic [M_W:0]               rnd   [3];
	logic [WORD_W-1:0]          qm    [3];
	logic [14:0]                qsat  [3];
	logic signed [WORD_W-1:0]   comp  [3];

	logic                       vld_s1, vld_s2, vld_s3;
	logic [M_W-1:0]             m_s1 [3];
	logic [2:0]                 neg_s1;
	slot_t                      slot_s1;
	logic                       neg_d_s1;
	logic [SQ_W-1:0]            sq_s2 [3];
	side_t                      side_s2, side_s3;
	logic [SUM_W-1:0]           sum_s3;

	assign words[0] = word_a;
	assign words[1] = word_b;
	assign words[2] = word_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			raw[i]   = words[i] & WORD_MASK;
			mag[i]   = raw[i][WORD_W-1] ? (MAG_W'(17'h10000) - {1'b0, raw[i]})
			                            : {1'b0, raw[i]};
			mprod[i] = mag[i] * SCALE_Q32;
		end
	end

	// stored components and squares from the scaled magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_full[i] = m_s1[i] * m_s1[i];
			rnd[i]     = {1'b0, m_s1[i]} + (M_W+1)'(33'h10000);
			qm[i]      = rnd[i][M_W:17];
			qsat[i]    = qm[i][WORD_W-1] ? Q15_MAX : qm[i][14:0];
			comp[i]    = neg_s1[i] ? -$signed({1'b0, qsat[i]}) : $signed({1'b0, qsat[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s1[i]   <= mprod[i][M_W-1:0];
			neg_s1[i] <= raw[i][WORD_W-1];
			sq_s2[i]  <= sq_full[i][2*M_W-1:4];
		end
		slot_s1  <= slot_t'({word_b[0], word_a[0]});
		neg_d_s1 <= word_c[0];

		side_s2.comp_a <= comp[0];
		side_s2.comp_b <= comp[1];
		side_s2.comp_c <= comp[2];
		side_s2.slot   <= slot_s1;
		side_s2.neg_d  <= neg_d_s1;

		sum_s3  <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		side_s3 <= side_s2;

		// a sum past one would give a negative radicand: clamp to zero
		rad_s4  <= (sum_s3 < ONE_Q60) ? {1'b0, ONE_Q60 - sum_s3} : '0;
		side_s4 <= side_s3;
	end

endmodule

[sv/pqd_sqrt_cell.sv]
// One square-root cell: retires one root bit per clock and hands its
// partial remainder, root and radicand on to the next cell. Depends on pqd_pkg.
`timescale 1ns / 1ps

module pqd_sqrt_cell import pqd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  side_t side_i,
	input  sqrt_t sq_i,
	output logic  vld_o,
	output side_t side_o,
	output sqrt_t sq_o
);

	logic [REM_W+1:0] cur, trial, diff;
	logic             ge;
	sqrt_t            nxt;
	logic             vld_q;
	side_t            side_q;
	sqrt_t            sq_q;

	always_comb begin
		cur      = {sq_i.rem, sq_i.rad[RAD_W-1 -: 2]};
		trial    = (REM_W+2)'({sq_i.root, 2'b01});
		diff     = cur - trial;
		ge       = (cur >= trial);
		nxt.rem  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
		nxt.root = {sq_i.root[ROOT_W-2:0], ge};
		nxt.rad  = {sq_i.rad[RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		sq_q   <= nxt;
	end

	assign vld_o  = vld_q;
	assign side_o = side_q;
	assign sq_o   = sq_q;

endmodule

[sv/pqd_out.sv]
// Output stage: rounds and saturates the root, applies its sign, places the
// four components into slots and registers the result beat. Depends on pqd_pkg.
`timescale 1ns / 1ps

module pqd_out import pqd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_i,
	input  side_t                    side_i,
	input  logic [ROOT_W-1:0]        root_i,
	output logic                     done,
	output logic signed [WORD_W-1:0] quat_x,
	output logic signed [WORD_W-1:0] quat_y,
	output logic signed [WORD_W-1:0] quat_z,
	output logic signed [WORD_W-1:0] quat_w
);

	logic [ROOT_W:0]          dsum;
	logic [MAG_W-1:0]         dm;
	logic [14:0]              dmag;
	logic signed [WORD_W-1:0] d;
	logic signed [WORD_W-1:0] q0, q1, q2, q3;
	logic                     done_q;
	logic signed [WORD_W-1:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;

	always_comb begin
		dsum = {1'b0, root_i} + (ROOT_W+1)'(32'h4000);
		dm   = dsum[ROOT_W:15];
		// a rebuilt component of exactly one saturates
		dmag = (dm[MAG_W-1] | dm[MAG_W-2]) ? Q15_MAX : dm[14:0];
		d    = side_i.neg_d ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

		unique case (side_i.slot)
			SLOT_ABCD: begin
				q0 = side_i.comp_a; q1 = side_i.comp_b; q2 = side_i.comp_c; q3 = d;
			end
			SLOT_BCDA: begin
				q0 = side_i.comp_b; q1 = side_i.comp_c; q2 = d; q3 = side_i.comp_a;
			end
			SLOT_CDAB: begin
				q0 = side_i.comp_c; q1 = d; q2 = side_i.comp_a; q3 = side_i.comp_b;
			end
			SLOT_DABC: begin
				q0 = d; q1 = side_i.comp_a; q2 = side_i.comp_b; q3 = side_i.comp_c;
			end
			default: begin
				q0 = side_i.comp_a; q1 = side_i.comp_b; q2 = side_i.comp_c; q3 = d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		quat_x_q <= q0;
		quat_y_q <= q1;
		quat_z_q <= q2;
		quat_w_q <= q3;
	end

	assign done   = done_q;
	assign quat_x = quat_x_q;
	assign quat_y = quat_y_q;
	assign quat_z = quat_z_q;
	assign quat_w = quat_w_q;

endmodule

[sv/packed_quaternion_decode.sv]
// Smallest-three quaternion decoder: one 48-bit key in per clock, one Q1.15
// quaternion out per key. Depends on pqd_pkg, pqd_front, pqd_sqrt_cell, pqd_out.
//
// A key is taken at any clock where start is high; busy stays low, so keys may
// arrive every cycle. Each result appears on quat_x..quat_w for one cycle with
// done high, in key order; the receiver cannot stall it and must take every
// beat. The pipeline is the 31-cell square-root chain (one root bit per cell)
// plus four front stages for scaling, squaring, summing and the radicand, and
// one output register.
`timescale 1ns / 1ps

module packed_quaternion_decode import pqd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [WORD_W-1:0]        word_a,
	input  logic [WORD_W-1:0]        word_b,
	input  logic [WORD_W-1:0]        word_c,
	output logic                     done,
	output logic signed [WORD_W-1:0] quat_x,
	output logic signed [WORD_W-1:0] quat_y,
	output logic signed [WORD_W-1:0] quat_z,
	output logic signed [WORD_W-1:0] quat_w
);

	logic             vld_f;
	side_t            side_f;
	logic [RAD_W-1:0] rad_f;

	logic  vld_c  [SQRT_STEPS+1];
	side_t side_c [SQRT_STEPS+1];
	sqrt_t sq_c   [SQRT_STEPS+1];

	// the pipeline never stalls
	assign busy = 1'b0;

	pqd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start & ~busy),
		.word_a (word_a),
		.word_b (word_b),
		.word_c (word_c),
		.vld_s4 (vld_f),
		.side_s4(side_f),
		.rad_s4 (rad_f)
	);

	assign vld_c[0]      = vld_f;
	assign side_c[0]     = side_f;
	assign sq_c[0].rem   = '0;
	assign sq_c[0].root  = '0;
	assign sq_c[0].rad   = rad_f;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
		pqd_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_c[g]),
			.side_i (side_c[g]),
			.sq_i   (sq_c[g]),
			.vld_o  (vld_c[g+1]),
			.side_o (side_c[g+1]),
			.sq_o   (sq_c[g+1])
		);
	end

	pqd_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld_c[SQRT_STEPS]),
		.side_i (side_c[SQRT_STEPS]),
		.root_i (sq_c[SQRT_STEPS].root),
		.done   (done),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.quat_w (quat_w)
	);

endmodule

[sv/pqd_checker.sv]
// Port-level checks for packed_quaternion_decode, attached by bind.
// Depends on pqd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pqd_checker import pqd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic [WORD_W-1:0]        word_a,
	input logic [WORD_W-1:0]        word_b,
	input logic [WORD_W-1:0]        word_c,
	input logic                     done,
	input logic signed [WORD_W-1:0] quat_x,
	input logic signed [WORD_W-1:0] quat_y,
	input logic signed [WORD_W-1:0] quat_z,
	input logic signed [WORD_W-1:0] quat_w
);

	// every accepted key yields exactly one result beat
	`ASSERT_CLK(a_beat_follows, clk, arst_n, (start && !busy) |-> ##PQD_LATENCY done, "missing result beat")
	`ASSERT_CLK(a_beat_has_key, clk, arst_n, done |-> $past(start && !busy, PQD_LATENCY), "result beat without a key")

	// zero components rebuild W as saturated one
	`ASSERT_CLK(a_identity, clk, arst_n, (start && !busy && word_a == 16'h0000 && word_b == 16'h0000 && word_c == 16'h0000) |-> ##PQD_LATENCY (quat_w == 16'sh7FFF && quat_x == 16'sh0000 && quat_y == 16'sh0000 && quat_z == 16'sh0000), "identity key decoded wrong")

	// low select bit alone moves the rebuilt component to Z
	`ASSERT_CLK(a_slot_z, clk, arst_n, (start && !busy && word_a == 16'h0001 && word_b == 16'h0000 && word_c == 16'h0000) |-> ##PQD_LATENCY (quat_z == 16'sh7FFF && quat_w == 16'sh0000), "slot placement wrong")

endmodule

bind packed_quaternion_decode pqd_checker u_pqd_checker (.*);
